/* rtl/core/swrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrd_pkg: shared types and constants of the range detector
// Widths, queue entry layout, cell control bundle and register indexes.
// ----------------------------------------------------------------------------
package swrd_pkg;

	localparam int WINDOW_MAX  = 1024;
	localparam int SAMPLE_BITS = 20;
	localparam int POS_W       = 32;
	localparam int LEN_W       = 11;
	localparam int RANGE_W     = 20;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 20;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LEN = 1'b0,
		REG_MAX_RANGE  = 1'b1
	} cfg_reg_t;

	// one queue entry held by a cell
	typedef struct packed {
		logic                   vld;
		logic [SAMPLE_BITS-1:0] val;
		logic [POS_W-1:0]       pos;
	} entry_t;

	// control broadcast to every cell of a queue
	typedef struct packed {
		logic                   step;     // update the chain this cycle
		logic                   shift;    // drop the head entry
		logic                   push;     // pop dominated tail, append new item
		logic                   keep_max; // 1: max queue, 0: min queue
		logic [SAMPLE_BITS-1:0] val;
		logic [POS_W-1:0]       pos;
	} cell_ctl_t;

endpackage

/* rtl/core/swrd_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrd_cell: one slot of a monotonic queue chain
// Takes its upper neighbor's entry on a head drop, clears itself when the
// new item dominates it, and captures the new item when it becomes the tail.
// ----------------------------------------------------------------------------
module swrd_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  swrd_pkg::cell_ctl_t ctl,
	input  swrd_pkg::entry_t   nbr_ent,   // entry of the next cell up
	input  logic               surv_in,   // lower cell keeps an entry
	output swrd_pkg::entry_t   ent,
	output logic               surv_out
);
	import swrd_pkg::*;

	logic                   vld_q;
	logic [SAMPLE_BITS-1:0] val_q;
	logic [POS_W-1:0]       pos_q;
	entry_t                 cur;
	entry_t                 w;
	entry_t                 ent_d;
	logic                   beats;
	logic                   surv;
	logic                   ins;

	assign cur = '{vld: vld_q, val: val_q, pos: pos_q};

	// entry after the head drop, then tail pop and append
	always_comb begin
		w     = ctl.shift ? nbr_ent : cur;
		beats = ctl.keep_max ? (w.val < ctl.val) : (w.val > ctl.val);
		surv  = w.vld && !(ctl.push && beats);
		ins   = ctl.push && !surv && surv_in;
		if (surv) begin
			ent_d = w;
		end else begin
			ent_d.vld = ins;
			ent_d.val = ctl.val;
			ent_d.pos = ctl.pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.step) begin
			vld_q <= ent_d.vld;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			val_q <= ent_d.val;
			pos_q <= ent_d.pos;
		end
	end

	assign ent      = cur;
	assign surv_out = surv;

endmodule

/* rtl/core/swrd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrd_queue: monotonic queue as a chain of cells
// Cell 0 holds the oldest entry (the window extreme); entries are packed
// toward cell 0 and ordered by position.
// ----------------------------------------------------------------------------
module swrd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  swrd_pkg::cell_ctl_t ctl,
	output swrd_pkg::entry_t    head
);
	import swrd_pkg::*;

	entry_t ent  [WINDOW_MAX];
	entry_t nbr  [WINDOW_MAX];
	logic   surv [WINDOW_MAX+1];

	assign surv[0] = 1'b1;

	for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
		// top cell sees an empty neighbor
		if (gi == WINDOW_MAX - 1) begin : g_top
			assign nbr[gi] = '0;
		end else begin : g_mid
			assign nbr[gi] = ent[gi+1];
		end

		swrd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.nbr_ent  (nbr[gi]),
			.surv_in  (surv[gi]),
			.ent      (ent[gi]),
			.surv_out (surv[gi+1])
		);
	end

	assign head = ent[0];

endmodule

/* rtl/core/sliding_window_range_detector_unit.sv */
`timescale 1ns / 1ps
// An accepted sample is registered in stage 1, then its result item in the output register.
// Throughput: one sample per cycle while no purge runs and a full output does not hold stage 1;
// each sample updates both cell chains together. After a window_len write, stale head entries
// are dropped one per cycle while input is held off; configuration writes are always taken.
// Reset: queues empty, position and sample count zero, window_len 1, max_range 0.
// ----------------------------------------------------------------------------
// sliding_window_range_detector_unit: quiet-window detector
// Tracks window max and min with two cell-chain monotonic queues and emits
// the start position of each full window whose max minus min is in range.
// ----------------------------------------------------------------------------
module sliding_window_range_detector_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [swrd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swrd_pkg::CFG_DATA_W-1:0]      cfg_data,
	// samples
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [swrd_pkg::SAMPLE_BITS-1:0]     sample,
	// results
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [swrd_pkg::POS_W-1:0]           start_position
);
	import swrd_pkg::*;

	logic [LEN_W-1:0]   window_len_q;
	logic [RANGE_W-1:0] max_range_q;
	logic [POS_W-1:0]   pos_q;
	logic [LEN_W-1:0]   seen_q;
	logic               purge_q;

	logic               vld_s1;
	logic               full_s1;
	logic [POS_W-1:0]   start_s1;

	logic               out_valid_q;
	logic [POS_W-1:0]   start_position_q;

	logic [LEN_W-1:0]   len_eff;
	logic [POS_W-1:0]   p_next;
	logic [LEN_W-1:0]   seen_next;
	logic               max_exp;
	logic               min_exp;
	logic               accept;
	logic               cfg_acc;
	logic               range_ok;
	logic               emit;
	logic               out_free;
	logic               s1_go;
	logic [SAMPLE_BITS-1:0] diff;

	cell_ctl_t max_ctl;
	cell_ctl_t min_ctl;
	entry_t    max_head;
	entry_t    min_head;

	// effective window length: zero means 1, saturate at the queue depth
	always_comb begin
		if (window_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (window_len_q > LEN_W'(WINDOW_MAX)) begin
			len_eff = LEN_W'(WINDOW_MAX);
		end else begin
			len_eff = window_len_q;
		end
	end

	assign p_next    = pos_q + POS_W'(1);
	assign seen_next = (seen_q == LEN_W'(WINDOW_MAX)) ? seen_q : seen_q + LEN_W'(1);

	// head expiry, ages taken modulo 2^32
	assign max_exp = max_head.vld && ((p_next - max_head.pos) >= POS_W'(len_eff));
	assign min_exp = min_head.vld && ((p_next - min_head.pos) >= POS_W'(len_eff));

	// result check on the updated heads
	assign diff     = max_head.val - min_head.val;
	assign range_ok = (max_head.val >= min_head.val) &&
	                  (POS_W'(diff) <= POS_W'(max_range_q));
	assign emit     = vld_s1 && full_s1 && range_ok;
	assign out_free = !out_valid_q || out_ready;
	assign s1_go    = !(full_s1 && range_ok) || out_free;

	assign in_ready  = !purge_q && (!vld_s1 || s1_go);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// chain control: a sample step pushes, a purge step only drops heads
	always_comb begin
		max_ctl.step     = accept || purge_q;
		max_ctl.shift    = max_exp;
		max_ctl.push     = accept;
		max_ctl.keep_max = 1'b1;
		max_ctl.val      = sample;
		max_ctl.pos      = p_next;
		min_ctl          = max_ctl;
		min_ctl.shift    = min_exp;
		min_ctl.keep_max = 1'b0;
	end

	swrd_queue u_max_q (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (max_ctl),
		.head   (max_head)
	);

	swrd_queue u_min_q (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (min_ctl),
		.head   (min_head)
	);

	// configuration registers and purge control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_W'(1);
			max_range_q  <= '0;
			purge_q      <= 1'b0;
		end else begin
			if (purge_q && !max_exp && !min_exp) begin
				purge_q <= 1'b0;
			end
			if (cfg_acc) begin
				case (cfg_reg_t'(cfg_index))
					REG_WINDOW_LEN: begin
						window_len_q <= cfg_data[LEN_W-1:0];
						purge_q      <= 1'b1;
					end
					REG_MAX_RANGE: begin
						max_range_q <= cfg_data[RANGE_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// sample position and saturating sample count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seen_q <= '0;
		end else if (accept) begin
			pos_q  <= p_next;
			seen_q <= seen_next;
		end
	end

	// stage 1: waits for the queue heads to settle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !s1_go);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			full_s1  <= (seen_next >= len_eff);
			start_s1 <= p_next - POS_W'(len_eff) + POS_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			start_position_q <= start_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign start_position = start_position_q;

endmodule

/* tb/sv/sliding_window_range_detector_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_range_detector_unit_tb: self-checking regression
// A driver feeds queued samples through the input handshake. A monitor keeps a
// mirror of the max/min deques and the window settings, predicts each quiet
// window start, and checks the results in order. Window settings change
// between phases. Both sides idle at random, and the receiver also holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module sliding_window_range_detector_unit_tb;
	import swrd_pkg::*;

	localparam int CLK_PERIOD        = 10;
	localparam int RESET_CYCLES      = 9;
	localparam int STALL_LIMIT       = 5000;
	localparam int DRAIN_CYCLES      = 6;
	localparam int LONG_HOLD         = 200;
	localparam int MAX_REPORTS       = 10;
	localparam int MAX_SAMPLE        = (1 << SAMPLE_BITS) - 1;
	localparam int FULL_WINDOW_ITEMS = WINDOW_MAX + 8;
	localparam int DQ_MAX            = 0;
	localparam int DQ_MIN            = 1;

	logic                   clk            = 1'b0;
	logic                   arst_n         = 1'b0;
	logic                   cfg_valid      = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index      = REG_WINDOW_LEN;
	logic [CFG_DATA_W-1:0]  cfg_data       = '0;
	logic                   in_valid       = 1'b0;
	logic                   in_ready;
	logic [SAMPLE_BITS-1:0] sample         = '0;
	logic                   out_valid;
	logic                   out_ready      = 1'b0;
	logic [POS_W-1:0]       start_position;

	// stimulus bookkeeping
	logic [SAMPLE_BITS-1:0] sample_q [$];
	int                     items_queued = 0;
	int                     items_taken  = 0;
	int                     tx_idle_pct  = 34;
	int                     rx_idle_pct  = 88;
	int                     hold_ticket  = 0;
	int                     hold_served  = 0;
	int                     hold_left    = 0;
	int                     quiet_cycles = 0;
	int                     mismatch_cnt = 0;

	// mirror of the detector
	logic [LEN_W-1:0]       win_cfg;
	logic [RANGE_W-1:0]     range_cfg;
	logic [POS_W-1:0]       pos_ctr;
	int                     seen_cnt;
	logic [SAMPLE_BITS-1:0] dq_val [2][WINDOW_MAX];
	logic [POS_W-1:0]       dq_pos [2][WINDOW_MAX];
	int                     dq_head [2];
	int                     dq_cnt [2];
	logic [POS_W-1:0]       start_pos_q [$];

	sliding_window_range_detector_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample         (sample),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.start_position (start_position)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// one step of a monotonic deque: expire, drop dominated tail, append
	task automatic deque_push(input int k, input logic [SAMPLE_BITS-1:0] v,
			input logic [POS_W-1:0] p, input int len);
		logic [SAMPLE_BITS-1:0] tail;
		logic [POS_W-1:0]       age;
		int                     slot;
		while (dq_cnt[k] > 0) begin
			age = p - dq_pos[k][dq_head[k]];
			if (age < POS_W'(len))
				break;
			dq_head[k] = (dq_head[k] + 1) % WINDOW_MAX;
			dq_cnt[k]--;
		end
		// an older equal value is kept
		while (dq_cnt[k] > 0) begin
			tail = dq_val[k][(dq_head[k] + dq_cnt[k] - 1) % WINDOW_MAX];
			if ((k == DQ_MAX) ? (tail < v) : (tail > v))
				dq_cnt[k]--;
			else
				break;
		end
		if (dq_cnt[k] < WINDOW_MAX) begin
			slot = (dq_head[k] + dq_cnt[k]) % WINDOW_MAX;
			dq_val[k][slot] = v;
			dq_pos[k][slot] = p;
			dq_cnt[k]++;
		end
	endtask

	// advance the mirror by one sample, queue the window start if quiet
	task automatic window_predict(input logic [SAMPLE_BITS-1:0] v);
		int len;
		if (win_cfg == '0)
			len = 1;
		else if (win_cfg > LEN_W'(WINDOW_MAX))
			len = WINDOW_MAX;
		else
			len = int'(win_cfg);
		pos_ctr = pos_ctr + 1'b1;
		if (seen_cnt < WINDOW_MAX)
			seen_cnt++;
		deque_push(DQ_MAX, v, pos_ctr, len);
		deque_push(DQ_MIN, v, pos_ctr, len);
		if (seen_cnt >= len &&
				dq_val[DQ_MAX][dq_head[DQ_MAX]] - dq_val[DQ_MIN][dq_head[DQ_MIN]] <= range_cfg)
			start_pos_q.insert(start_pos_q.size(), pos_ctr - POS_W'(len) + 1'b1);
	endtask

	task automatic note_mismatch(input string what, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (mismatch_cnt < MAX_REPORTS)
			$display("mismatch (%s): expected start_position %0d, got %0d", what, want, got);
		mismatch_cnt++;
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample   <= '0;
		end else if (!in_valid || in_ready) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				sample   <= sample_q[0];
				sample_q.delete(0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, with an occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_ticket) begin
			out_ready   <= 1'b0;
			hold_left   <= LONG_HOLD;
			hold_served <= hold_ticket;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// monitor: track settings and samples, check results in order
	always @(posedge clk or negedge arst_n) begin : monitor
		logic [POS_W-1:0] want;
		if (!arst_n) begin
			win_cfg   = LEN_W'(1);
			range_cfg = '0;
			pos_ctr   = '0;
			seen_cnt  = 0;
			dq_head   = '{0, 0};
			dq_cnt    = '{0, 0};
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_LEN: win_cfg = cfg_data[LEN_W-1:0];
					REG_MAX_RANGE:  range_cfg = cfg_data[RANGE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				window_predict(sample);
				items_taken++;
			end
			if (out_valid && out_ready) begin
				if (start_pos_q.size() == 0) begin
					note_mismatch("no result pending", 'x, start_position);
				end else begin
					want = start_pos_q[0];
					start_pos_q.delete(0);
					if (start_position !== want)
						note_mismatch("wrong start", want, start_position);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
				(out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("sliding_window_range_detector_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic enqueue(input logic [SAMPLE_BITS-1:0] v);
		sample_q.insert(sample_q.size(), v);
		items_queued++;
	endtask

	// wait until every item is taken and every result is back
	task automatic settle();
		while (items_taken != items_queued || start_pos_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] rng);
		settle();
		write_reg(REG_WINDOW_LEN, win);
		write_reg(REG_MAX_RANGE, rng);
	endtask

	// quiet runs around a random level, broken by short noise bursts
	task automatic load_samples(input int n, input int run_hint, input int spread_hint);
		int                     run_left;
		int                     spread;
		int                     off;
		bit                     noisy;
		logic [SAMPLE_BITS-1:0] base;
		logic [SAMPLE_BITS-1:0] v;
		run_left = 0;
		spread   = 0;
		noisy    = 1'b0;
		base     = '0;
		repeat (n) begin
			if (run_left == 0) begin
				noisy    = ($urandom_range(3) == 0);
				run_left = noisy ? $urandom_range(1, 3) : $urandom_range(1, 3 * run_hint + 4);
				base     = SAMPLE_BITS'($urandom);
				case ($urandom_range(3))
					0:       spread = 0;
					1:       spread = spread_hint;
					2:       spread = spread_hint + 1;
					default: spread = $urandom_range(0, 2 * spread_hint + 1);
				endcase
				if (spread > MAX_SAMPLE)
					spread = MAX_SAMPLE;
			end
			off = $urandom_range(0, spread);
			if (noisy)
				v = SAMPLE_BITS'($urandom);
			else if (int'(base) > MAX_SAMPLE - spread)
				v = base - SAMPLE_BITS'(off);
			else
				v = base + SAMPLE_BITS'(off);
			enqueue(v);
			run_left--;
		end
	endtask

	initial begin
		logic [SAMPLE_BITS-1:0] corner_vals [6] = '{20'h00000, 20'hFFFFF, 20'h80000,
			20'h7FFFF, 20'hAAAAA, 20'h55555};
		logic [SAMPLE_BITS-1:0] tie_vals [12] = '{20'd5, 20'd5, 20'd5, 20'd9, 20'd8,
			20'd7, 20'd7, 20'd7, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF};
		logic [CFG_DATA_W-1:0]  win_plan [8] = '{20'd4, 20'd17, 20'd1, 20'hF0009,
			20'd64, 20'd5, 20'd1024, 20'd3};
		logic [CFG_DATA_W-1:0]  range_plan [8] = '{20'h10, 20'h100, 20'h0, 20'hFFFFF,
			20'h40, 20'h3, 20'hFFFFF, 20'h0};
		int                     hint_plan [8] = '{4, 17, 1, 9, 64, 5, 1024, 3};
		int                     count_plan [8] = '{90, 110, 120, 80, 130, 100, 120, 20};
		int                     n;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: window of one, every sample is a quiet window
		foreach (corner_vals[i])
			enqueue(corner_vals[i]);

		// short window, zero range: ties, falls and the sample extremes
		configure(20'd3, 20'd0);
		foreach (tie_vals[i])
			enqueue(tie_vals[i]);

		// window length zero acts as one
		configure(20'd0, 20'hFFFFF);
		enqueue(20'h00000);
		enqueue(20'hFFFFF);

		// oversize window saturates; not enough samples seen yet
		configure(20'h7FF, 20'd10);
		enqueue(20'd3);
		enqueue(20'd4);
		enqueue(20'd5);

		// random phases; window changes clear stale entries in between
		foreach (win_plan[ph]) begin
			settle();
			if (ph == 3) begin
				tx_idle_pct = 88;
				rx_idle_pct = 34;
			end else if (ph == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			configure(win_plan[ph], range_plan[ph]);
			if (ph == 2)
				hold_ticket++;
			n = count_plan[ph];
			// full-size window needs enough samples since reset to report
			if (ph == 6 && n < FULL_WINDOW_ITEMS - items_queued)
				n = FULL_WINDOW_ITEMS - items_queued;
			load_samples(n, hint_plan[ph], int'(range_plan[ph]));
		end

		settle();
		if (mismatch_cnt == 0)
			$display("sliding_window_range_detector_unit regression: pass");
		else
			$display("sliding_window_range_detector_unit regression: fail");
		$finish;
	end

endmodule
